FILE: hw/rtl/bdrm_pkg.sv
// Shared types, mode codes and saturation helper for the block-diagonal
// 3x3 matrix-vector unit. No dependencies.
`timescale 1ns / 1ps

package bdrm_pkg;

	localparam int NUM_BLOCKS = 256;
	localparam int BLK_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int ROW_COUNT = 3 * NUM_BLOCKS;

	localparam logic [2:0] MODE_SET  = 3'd0;
	localparam logic [2:0] MODE_ADD  = 3'd1;
	localparam logic [2:0] MODE_READ = 3'd2;
	localparam logic [2:0] MODE_MUL  = 3'd3;
	localparam logic [2:0] MODE_TMUL = 3'd4;

	typedef logic signed [31:0] word_t;
	typedef word_t [8:0] brow_t;
	typedef word_t [2:0] vec3_t;
	typedef logic signed [47:0] prod_t;
	typedef logic signed [49:0] wide_t;

	typedef struct packed {
		logic             en;
		logic [BLK_W-1:0] blk;
		brow_t            data;
	} wr_req_t;

	function automatic word_t sat32(input wide_t v);
		word_t r;
		if (&v[49:31] || ~|v[49:31]) begin
			r = v[31:0];
		end else if (v[49]) begin
			r = 32'sh8000_0000;
		end else begin
			r = 32'sh7FFF_FFFF;
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/bdrm_store.sv
// Block store: one row of nine words per diagonal block, a valid bit per
// block and a last-write bypass. Depends on bdrm_pkg.
`timescale 1ns / 1ps

module bdrm_store (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [bdrm_pkg::BLK_W-1:0]   rd_blk,
	input  logic [bdrm_pkg::BLK_W-1:0]   cur_blk,
	input  bdrm_pkg::wr_req_t            wr,
	output bdrm_pkg::brow_t              eff_row
);

	bdrm_pkg::brow_t mem [bdrm_pkg::NUM_BLOCKS];
	bdrm_pkg::brow_t rd_data_q;
	logic rd_valid_q;
	logic [bdrm_pkg::NUM_BLOCKS-1:0] valid_q;
	logic fwd_en_q;
	logic [bdrm_pkg::BLK_W-1:0] fwd_blk_q;
	bdrm_pkg::brow_t fwd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.blk] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_blk];
		end
		if (wr.en) begin
			fwd_blk_q <= wr.blk;
			fwd_data_q <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_valid_q <= 1'b0;
			fwd_en_q <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.blk] <= 1'b1;
				fwd_en_q <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_blk];
			end
		end
	end

	always_comb begin
		if (fwd_en_q && fwd_blk_q == cur_blk) begin
			eff_row = fwd_data_q;
		end else if (rd_valid_q) begin
			eff_row = rd_data_q;
		end else begin
			eff_row = '0;
		end
	end

endmodule

FILE: hw/rtl/bdrm_matvec.sv
// Product register stage and saturating three-term sums for the 3x3 times
// 3-vector product. Depends on bdrm_pkg.
`timescale 1ns / 1ps

module bdrm_matvec (
	input  logic             clk,
	input  logic             en,
	input  bdrm_pkg::brow_t  mat,
	input  bdrm_pkg::vec3_t  x,
	output bdrm_pkg::vec3_t  y
);

	bdrm_pkg::prod_t p_s2 [9];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					p_s2[i*3+j] <= 48'((64'($signed(mat[i*3+j])) *
						64'($signed(x[j]))) >>> 16);
				end
			end
		end
	end

	always_comb begin
		bdrm_pkg::wide_t sum;
		for (int i = 0; i < 3; i++) begin
			sum = 50'(p_s2[i*3]) + 50'(p_s2[i*3+1]) + 50'(p_s2[i*3+2]);
			y[i] = bdrm_pkg::sat32(sum);
		end
	end

endmodule

FILE: hw/rtl/block_diag_rotation_matvec.sv
// Block-diagonal 3x3 store with element set, add, read and (transpose) multiply.
// Registered stages: item fields (s1), products (s2), results (s3). Throughput: one item per
// cycle while res_stall is low, bounded by the read-modify-write of a block row with bypass.
// Reset: asynchronous, clears pipeline valids and per-block valid bits at once;
// unwritten blocks read as zero, no clearing pass.
// Depends on bdrm_pkg, bdrm_store, bdrm_matvec.
`timescale 1ns / 1ps

module block_diag_rotation_matvec (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  logic [2:0]           mode,
	input  logic [9:0]           row,
	input  logic [9:0]           col,
	input  bdrm_pkg::word_t      value,
	input  bdrm_pkg::word_t      x0,
	input  bdrm_pkg::word_t      x1,
	input  bdrm_pkg::word_t      x2,
	output logic                 res_valid,
	input  logic                 res_stall,
	output bdrm_pkg::word_t      y0,
	output bdrm_pkg::word_t      y1,
	output bdrm_pkg::word_t      y2,
	output bdrm_pkg::word_t      read_value,
	output logic                 in_block
);

	logic ready_s1, ready_s2, ready_s3, accept, adv_s1, load_s3;
	logic v_s1, v_s2, v_s3;

	logic [8:0] blk_in;
	logic [9:0] base_in;
	logic row_ok_in, hit_in;
	logic [1:0] roff_in, coff_in;
	logic [3:0] elem_in;

	logic [2:0] mode_s1;
	logic [bdrm_pkg::BLK_W-1:0] blk_s1;
	logic row_ok_s1, hit_s1;
	logic [3:0] elem_s1;
	bdrm_pkg::word_t value_s1;
	bdrm_pkg::vec3_t x_s1;

	bdrm_pkg::brow_t er, new_row, opm;
	bdrm_pkg::word_t cur, rdv;
	logic signed [32:0] add_sum;
	logic flag, mul_ok;
	bdrm_pkg::wr_req_t wr;
	bdrm_pkg::vec3_t y_mv;

	logic mul_s2, flag_s2;
	bdrm_pkg::word_t rdv_s2;

	assign ready_s3 = !v_s3 || !res_stall;
	assign ready_s2 = !v_s2 || ready_s3;
	assign ready_s1 = !v_s1 || ready_s2;
	assign cmd_stall = !ready_s1;
	assign accept = cmd_valid && ready_s1;
	assign adv_s1 = v_s1 && ready_s2;
	assign load_s3 = v_s2 && ready_s3;

	assign blk_in = 9'((20'(row) * 20'd683) >> 11);
	assign base_in = 10'(11'(blk_in) * 11'd3);
	assign row_ok_in = 32'(row) < 32'(bdrm_pkg::ROW_COUNT);
	assign hit_in = row_ok_in && (col >= base_in) && (11'(col) <= 11'(base_in) + 11'd2);
	assign roff_in = 2'(row - base_in);
	assign coff_in = 2'(col - base_in);
	assign elem_in = 4'(4'(roff_in) * 4'd3 + 4'(coff_in));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (ready_s1) begin
				v_s1 <= cmd_valid;
			end
			if (ready_s2) begin
				v_s2 <= v_s1;
			end
			if (ready_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= mode;
			blk_s1 <= bdrm_pkg::BLK_W'(blk_in);
			row_ok_s1 <= row_ok_in;
			hit_s1 <= hit_in;
			elem_s1 <= elem_in;
			value_s1 <= value;
			x_s1[0] <= x0;
			x_s1[1] <= x1;
			x_s1[2] <= x2;
		end
	end

	bdrm_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_blk  (bdrm_pkg::BLK_W'(blk_in)),
		.cur_blk (blk_s1),
		.wr      (wr),
		.eff_row (er)
	);

	always_comb begin
		cur = er[elem_s1];
		add_sum = 33'(cur) + 33'(value_s1);
		new_row = er;
		if (mode_s1 == bdrm_pkg::MODE_SET) begin
			new_row[elem_s1] = value_s1;
		end else begin
			new_row[elem_s1] = bdrm_pkg::sat32(50'(add_sum));
		end
		wr.en = adv_s1 && hit_s1 &&
			(mode_s1 == bdrm_pkg::MODE_SET || mode_s1 == bdrm_pkg::MODE_ADD);
		wr.blk = blk_s1;
		wr.data = new_row;
		rdv = (hit_s1 && mode_s1 == bdrm_pkg::MODE_READ) ? cur : '0;
		case (mode_s1) inside
			bdrm_pkg::MODE_SET, bdrm_pkg::MODE_ADD, bdrm_pkg::MODE_READ: flag = hit_s1;
			bdrm_pkg::MODE_MUL, bdrm_pkg::MODE_TMUL: flag = row_ok_s1;
			default: flag = 1'b0;
		endcase
		mul_ok = row_ok_s1 &&
			(mode_s1 == bdrm_pkg::MODE_MUL || mode_s1 == bdrm_pkg::MODE_TMUL);
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				opm[i*3+j] = (mode_s1 == bdrm_pkg::MODE_MUL) ? er[i*3+j] : er[j*3+i];
			end
		end
	end

	bdrm_matvec u_matvec (
		.clk (clk),
		.en  (adv_s1),
		.mat (opm),
		.x   (x_s1),
		.y   (y_mv)
	);

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			mul_s2 <= mul_ok;
			flag_s2 <= flag;
			rdv_s2 <= rdv;
		end
		if (load_s3) begin
			y0 <= mul_s2 ? y_mv[0] : '0;
			y1 <= mul_s2 ? y_mv[1] : '0;
			y2 <= mul_s2 ? y_mv[2] : '0;
			read_value <= rdv_s2;
			in_block <= flag_s2;
		end
	end

	assign res_valid = v_s3;

`ifndef ASSERT_OFF
	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && v_s3 && res_stall) |-> cmd_stall)
		else $error("item accepted into a full pipeline");

	a_write_moves: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |=> v_s2)
		else $error("store written without the item moving on");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !in_block) |->
			(read_value == '0 && y0 == '0 && y1 == '0 && y2 == '0))
		else $error("nonzero result outside the diagonal block");

	a_write_hit: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> (hit_s1 && row_ok_s1 && v_s1))
		else $error("store write outside the diagonal block");
`endif

endmodule

FILE: verif/tb_block_diag_rotation_matvec.sv
// Self-checking testbench for block_diag_rotation_matvec: directed table, then random
// items; checked against fixed results or a built-in Q16.16 block-diagonal store predictor.
// Depends on bdrm_pkg and the block_diag_rotation_matvec RTL.
`timescale 1ns / 1ps

module tb_block_diag_rotation_matvec;

	import bdrm_pkg::*;

	localparam logic [2:0] MODE_SPARE_LO = 3'd5;
	localparam int ROW_LIMIT = 1023;
	localparam int STORE_WORDS = 9 * NUM_BLOCKS;
	localparam int GAP_MAX = 6;
	localparam int HOLD_CYCLES = 300;
	localparam int N_RANDOM = 1300;
	localparam int CHUNK = 100;
	localparam int DRAIN_CYCLES = 10;
	localparam int LIMIT_NS = 400000;
	localparam int PRINT_MAX = 100;

	localparam word_t ZERO = 32'sh0000_0000;
	localparam word_t ONE = 32'sh0001_0000;
	localparam word_t NEG_ONE = -32'sh0001_0000;
	localparam word_t QMAX = 32'sh7FFF_FFFF;
	localparam word_t QMIN = 32'sh8000_0000;
	localparam word_t LSB_NEG = 32'shFFFF_FFFF;

	typedef struct packed {
		logic [2:0] mode;
		logic [9:0] row;
		logic [9:0] col;
		word_t      value;
		word_t      x0;
		word_t      x1;
		word_t      x2;
	} cmd_t;

	typedef struct packed {
		word_t y0;
		word_t y1;
		word_t y2;
		word_t rd;
		logic  hit;
	} res_t;

	typedef struct packed {
		cmd_t c;
		logic known;
		res_t e;
	} dir_row_t;

	localparam res_t HIT_ZERO = '{ZERO, ZERO, ZERO, ZERO, 1'b1};
	localparam res_t MISS_ZERO = '{ZERO, ZERO, ZERO, ZERO, 1'b0};

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cmd_valid;
	logic       cmd_stall;
	logic [2:0] mode;
	logic [9:0] row;
	logic [9:0] col;
	word_t      value;
	word_t      x0;
	word_t      x1;
	word_t      x2;
	logic       res_valid;
	logic       res_stall;
	word_t      y0;
	word_t      y1;
	word_t      y2;
	word_t      read_value;
	logic       in_block;

	word_t    elem_mem [0:STORE_WORDS-1];
	res_t     pending_results [$];
	dir_row_t dir_tab [$];
	int       errors = 0;
	bit       tx_idle = 1'b1;
	bit       rx_idle = 1'b1;
	bit       hold_request = 1'b0;

	block_diag_rotation_matvec DUT (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#(LIMIT_NS);
		$display("tb_block_diag_rotation_matvec NOT OK");
		$finish;
	end

	task automatic report(input string msg);
		if (errors < PRINT_MAX) begin
			$display("ERROR @%0t: %s", $time, msg);
		end
		errors++;
	endtask

	function automatic word_t clamp32(input longint v);
		if (v > longint'(QMAX)) begin
			return QMAX;
		end
		if (v < longint'(QMIN)) begin
			return QMIN;
		end
		return word_t'(v);
	endfunction

	// floor of the exact product shifted down by 16
	function automatic longint qprod(input word_t a, input word_t b);
		longint p;
		p = longint'(a) * longint'(b);
		return p >>> 16;
	endfunction

	function automatic res_t compute_result(input cmd_t c);
		int     r;
		int     k;
		int     base;
		int     idx;
		int     blk;
		bit     row_ok;
		bit     hit;
		word_t  m [9];
		word_t  xv [3];
		word_t  yv [3];
		longint acc;
		res_t   o;
		r = c.row;
		k = c.col;
		base = (r / 3) * 3;
		row_ok = r < ROW_COUNT;
		hit = row_ok && k >= base && k <= base + 2;
		idx = r * 3 + (k - base);
		o = MISS_ZERO;
		if (c.mode <= MODE_READ) begin
			o.hit = hit;
			if (hit) begin
				case (c.mode)
					MODE_SET: elem_mem[idx] = c.value;
					MODE_ADD: elem_mem[idx] =
						clamp32(longint'(elem_mem[idx]) + longint'(c.value));
					default: o.rd = elem_mem[idx];
				endcase
			end
		end else if (c.mode <= MODE_TMUL && row_ok) begin
			blk = (r / 3) * 9;
			for (int i = 0; i < 9; i++) begin
				m[i] = elem_mem[blk + i];
			end
			xv[0] = c.x0;
			xv[1] = c.x1;
			xv[2] = c.x2;
			for (int i = 0; i < 3; i++) begin
				acc = 0;
				for (int j = 0; j < 3; j++) begin
					acc += qprod((c.mode == MODE_MUL) ? m[3 * i + j] : m[i + 3 * j], xv[j]);
				end
				yv[i] = clamp32(acc);
			end
			o.y0 = yv[0];
			o.y1 = yv[1];
			o.y2 = yv[2];
			o.hit = 1'b1;
		end
		return o;
	endfunction

	function automatic word_t rand_word();
		int sel;
		sel = $urandom_range(0, 19);
		if (sel < 8) begin
			return word_t'(int'($urandom_range(0, 1048576)) - 524288);
		end
		if (sel < 11) begin
			case ($urandom_range(0, 5))
				0: return QMAX;
				1: return QMIN;
				2: return ZERO;
				3: return LSB_NEG;
				4: return ONE;
				default: return NEG_ONE;
			endcase
		end
		return word_t'($urandom);
	endfunction

	function automatic cmd_t rand_cmd();
		cmd_t c;
		int   pick;
		int   blk;
		int   r;
		int   base;
		pick = $urandom_range(0, 99);
		if (pick < 22) begin
			c.mode = MODE_SET;
		end else if (pick < 40) begin
			c.mode = MODE_ADD;
		end else if (pick < 60) begin
			c.mode = MODE_READ;
		end else if (pick < 78) begin
			c.mode = MODE_MUL;
		end else if (pick < 96) begin
			c.mode = MODE_TMUL;
		end else begin
			c.mode = 3'(MODE_SPARE_LO + $urandom_range(0, 2));
		end
		// keep most traffic on a few blocks so reads and products see written data
		pick = $urandom_range(0, 19);
		if (pick < 17) begin
			blk = $urandom_range(0, 7);
			if (blk >= 4) begin
				blk = NUM_BLOCKS - 1 - (blk - 4);
			end
			r = blk * 3 + $urandom_range(0, 2);
		end else if (pick < 19) begin
			r = $urandom_range(0, ROW_COUNT - 1);
		end else begin
			r = $urandom_range(ROW_COUNT, ROW_LIMIT);
		end
		base = (r / 3) * 3;
		c.row = 10'(r);
		if ($urandom_range(0, 9) < 8) begin
			c.col = 10'(base + $urandom_range(0, 2));
		end else begin
			c.col = 10'($urandom_range(0, ROW_LIMIT));
		end
		c.value = rand_word();
		c.x0 = rand_word();
		c.x1 = rand_word();
		c.x2 = rand_word();
		return c;
	endfunction

	function automatic res_t rd_hit(input word_t v);
		return '{ZERO, ZERO, ZERO, v, 1'b1};
	endfunction

	function automatic void tab(input cmd_t c, input logic known, input res_t e);
		dir_tab.push_back('{c, known, e});
	endfunction

	task automatic offer(input cmd_t c, input logic known, input res_t fixed);
		int   gap;
		res_t r;
		gap = tx_idle ? $urandom_range(0, GAP_MAX) : 0;
		if (gap != 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		mode <= c.mode;
		row <= c.row;
		col <= c.col;
		value <= c.value;
		x0 <= c.x0;
		x1 <= c.x1;
		x2 <= c.x2;
		do @(posedge clk); while (cmd_stall);
		r = compute_result(c);
		pending_results.push_back(known ? fixed : r);
	endtask

	task automatic check_result(input res_t got);
		res_t want;
		if (pending_results.size() == 0) begin
			report("result with no item pending");
			return;
		end
		want = pending_results.pop_front();
		if (got.y0 !== want.y0) begin
			report($sformatf("y0 got %h want %h", got.y0, want.y0));
		end
		if (got.y1 !== want.y1) begin
			report($sformatf("y1 got %h want %h", got.y1, want.y1));
		end
		if (got.y2 !== want.y2) begin
			report($sformatf("y2 got %h want %h", got.y2, want.y2));
		end
		if (got.rd !== want.rd) begin
			report($sformatf("read_value got %h want %h", got.rd, want.rd));
		end
		if (got.hit !== want.hit) begin
			report($sformatf("in_block got %b want %b", got.hit, want.hit));
		end
	endtask

	initial begin
		int   stall_left;
		int   hold_left;
		res_t got;
		stall_left = 0;
		hold_left = 0;
		res_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_valid && !res_stall) begin
				got = '{y0, y1, y2, read_value, in_block};
				check_result(got);
				stall_left = rx_idle ? $urandom_range(0, GAP_MAX) : 0;
			end
			if (hold_request) begin
				hold_left = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		mode = MODE_SET;
		row = '0;
		col = '0;
		value = ZERO;
		x0 = ZERO;
		x1 = ZERO;
		x2 = ZERO;
		for (int i = 0; i < STORE_WORDS; i++) begin
			elem_mem[i] = ZERO;
		end

		tab('{MODE_READ, 10'd0, 10'd0, ZERO, ZERO, ZERO, ZERO}, 1, HIT_ZERO);
		tab('{MODE_MUL, 10'd0, 10'd0, ZERO, QMAX, QMIN, ONE}, 1, HIT_ZERO);
		tab('{MODE_TMUL, 10'd767, 10'd0, ZERO, QMIN, QMAX, QMIN}, 1, HIT_ZERO);
		tab('{MODE_SET, 10'd0, 10'd0, QMAX, ZERO, ZERO, ZERO}, 1, HIT_ZERO);
		tab('{MODE_SET, 10'd0, 10'd3, ONE, ZERO, ZERO, ZERO}, 1, MISS_ZERO);
		tab('{MODE_ADD, 10'd0, 10'd0, QMAX, ZERO, ZERO, ZERO}, 1, HIT_ZERO);
		tab('{MODE_READ, 10'd0, 10'd0, ZERO, ZERO, ZERO, ZERO}, 1, rd_hit(QMAX));
		tab('{MODE_ADD, 10'd0, 10'd0, QMIN, ZERO, ZERO, ZERO}, 1, HIT_ZERO);
		tab('{MODE_ADD, 10'd0, 10'd0, QMIN, ZERO, ZERO, ZERO}, 1, HIT_ZERO);
		tab('{MODE_READ, 10'd0, 10'd0, ZERO, ZERO, ZERO, ZERO}, 1, rd_hit(QMIN));
		tab('{MODE_READ, 10'd767, 10'd764, ZERO, ZERO, ZERO, ZERO}, 1, MISS_ZERO);
		tab('{MODE_SET, 10'd768, 10'd768, QMAX, ZERO, ZERO, ZERO}, 1, MISS_ZERO);
		tab('{MODE_READ, 10'd1023, 10'd1023, ZERO, ZERO, ZERO, ZERO}, 1, MISS_ZERO);
		tab('{MODE_MUL, 10'd1023, 10'd1023, ZERO, QMAX, QMAX, QMAX}, 1, MISS_ZERO);
		tab('{MODE_SPARE_LO, 10'd0, 10'd0, QMAX, QMAX, QMAX, QMAX}, 1, MISS_ZERO);
		tab('{3'(MODE_SPARE_LO + 1), 10'd1, 10'd1, QMIN, QMIN, QMIN, QMIN}, 1, MISS_ZERO);
		tab('{3'(MODE_SPARE_LO + 2), 10'd1023, 10'd1023, QMAX, ONE, ONE, ONE}, 1, MISS_ZERO);
		tab('{MODE_SET, 10'd767, 10'd767, QMIN, ZERO, ZERO, ZERO}, 1, HIT_ZERO);
		tab('{MODE_SET, 10'd766, 10'd765, QMAX, ZERO, ZERO, ZERO}, 1, HIT_ZERO);
		tab('{MODE_SET, 10'd765, 10'd766, NEG_ONE, ZERO, ZERO, ZERO}, 1, HIT_ZERO);
		tab('{MODE_SET, 10'd1, 10'd1, LSB_NEG, ZERO, ZERO, ZERO}, 0, MISS_ZERO);
		tab('{MODE_SET, 10'd1, 10'd2, 32'shFFFF_FFFD, ZERO, ZERO, ZERO}, 0, MISS_ZERO);
		tab('{MODE_MUL, 10'd0, 10'd0, ZERO, 32'sh0001_8000, 32'sh1, QMIN}, 0, MISS_ZERO);
		tab('{MODE_TMUL, 10'd2, 10'd0, ZERO, QMAX, QMAX, QMAX}, 0, MISS_ZERO);
		tab('{MODE_MUL, 10'd767, 10'd0, ZERO, QMIN, QMIN, QMIN}, 0, MISS_ZERO);
		tab('{MODE_TMUL, 10'd766, 10'd0, ZERO, QMAX, NEG_ONE, ONE}, 0, MISS_ZERO);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (dir_tab[i]) begin
			offer(dir_tab[i].c, dir_tab[i].known, dir_tab[i].e);
		end

		// hold the sender until the pipeline is empty
		cmd_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n % CHUNK == 0) begin
				case (n / CHUNK)
					0: begin
						tx_idle = 1'b0;
						rx_idle = 1'b0;
					end
					3: begin
						tx_idle = 1'b0;
						rx_idle = 1'b1;
						hold_request = 1'b1;
					end
					default: begin
						tx_idle = $urandom_range(0, 3) != 0;
						rx_idle = $urandom_range(0, 3) != 0;
					end
				endcase
			end
			offer(rand_cmd(), 0, MISS_ZERO);
		end
		cmd_valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("tb_block_diag_rotation_matvec OK");
		end else begin
			$display("tb_block_diag_rotation_matvec NOT OK");
		end
		$finish;
	end

endmodule
